// ----- sv/hot_air_station_controller_core_macros.svh -----
// Assertion macros shared by the hot-air station controller modules.
`ifndef HOT_AIR_STATION_CONTROLLER_CORE_MACROS_SVH
`define HOT_AIR_STATION_CONTROLLER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition a holds in a cycle, so c holds in the same cycle.
`define HASC_ASSERT_IMPLY(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("hasc implication check failed");
// Condition a holds in a cycle, so c holds in the next cycle.
`define HASC_ASSERT_NEXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("hasc next-cycle check failed");
`else
`define HASC_ASSERT_IMPLY(lbl, ck, rn, a, c)
`define HASC_ASSERT_NEXT(lbl, ck, rn, a, c)
`endif
`endif

// ----- sv/hasc_pkg.sv -----
// Shared types and constants of the hot-air station controller.
package hasc_pkg;

    localparam logic [15:0] MIN_SET_TEMP = 16'd100;
    localparam logic [15:0] MAX_SET_TEMP = 16'd450;
    localparam int NUM_W = 28;
    localparam int MAG_W = NUM_W - 1;
    localparam int CNT_W = $clog2(MAG_W);

    typedef enum logic [3:0] {
        OP_SAMPLE  = 4'd0,
        OP_HOLDER  = 4'd1,
        OP_FAN     = 4'd2,
        OP_TEMP    = 4'd3,
        OP_POWER   = 4'd4,
        OP_CAL     = 4'd5,
        OP_CAPTURE = 4'd6,
        OP_ON      = 4'd7,
        OP_OFF     = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_HEAT   = 2'd1,
        MODE_PARKED = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [3:0] op;
        logic [9:0] adc_sample;
        logic       clockwise;
        logic       on_stand;
        logic       cal_point;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         power_state;
        logic [7:0]         fan_duty;
        logic               fan_drive_on;
        logic               heater_drive_on;
        logic               led_lit;
        logic [6:0]         fan_percent;
        logic [15:0]        target_temp;
        logic [6:0]         power_percent;
        logic signed [15:0] measured_temp;
        logic [15:0]        cal_temp_low;
        logic [15:0]        cal_temp_high;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic apply;
        logic mul;
        logic sum;
        logic div_step;
        logic fin;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_sample;
        logic zero_span;
        logic div_done;
        logic out_busy;
    } sts_t;

endpackage

// ----- sv/hasc_in_if.sv -----
// Input event channel: valid, ready and one event beat.
interface hasc_in_if
    import hasc_pkg::*;
;
    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/hasc_out_if.sv -----
// Result channel: valid, ready and one status beat.
interface hasc_out_if
    import hasc_pkg::*;
;
    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/hasc_ctrl.sv -----
// Controller state machine sequencing event handling and conversion.
`include "hot_air_station_controller_core_macros.svh"
module hasc_ctrl
    import hasc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.apply = 1'b1;
                    state_next = sts.is_sample ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
                state_next = sts.zero_span ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A non-sample event goes straight to the result stage.
    `HASC_ASSERT_NEXT(a_fast_event, clk, rst_n, cmd.apply && !sts.is_sample, state_reg == ST_OUT)
    // The last division step hands over to the finishing stage.
    `HASC_ASSERT_NEXT(a_div_exit, clk, rst_n, state_reg == ST_DIV && sts.div_done, state_reg == ST_FIN)
    // A free result slot always releases the result stage.
    `HASC_ASSERT_NEXT(a_out_release, clk, rst_n, state_reg == ST_OUT && !sts.out_busy, state_reg == ST_IDLE)
    // Only one stage command is active at a time.
    `HASC_ASSERT_IMPLY(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule

// ----- sv/hasc_dp.sv -----
// Datapath: controller state, event updates, calibration divider and result register.
`include "hot_air_station_controller_core_macros.svh"
module hasc_dp
    import hasc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    output sts_t      sts,
    input  in_beat_t  in_data,
    input  logic      out_ready,
    output logic      out_valid,
    output out_beat_t out_data
);

    mode_t              mode_reg;
    logic [6:0]         fan_reg;
    logic [6:0]         saved_reg;
    logic [15:0]        setp_reg;
    logic [6:0]         pwr_reg;
    logic [15:0]        rta_reg;
    logic [15:0]        rtb_reg;
    logic [9:0]         raa_reg;
    logic [9:0]         rab_reg;
    logic [9:0]         last_adc_reg;
    logic               led_reg;
    logic signed [15:0] last_temp_reg;
    logic [15:0]        cta_reg;
    logic [15:0]        ctb_reg;
    logic               out_valid_reg;
    out_beat_t          out_reg;

    // Conversion working registers.
    logic signed [10:0]      da_reg;
    logic signed [16:0]      dt_reg;
    logic signed [10:0]      off_reg;
    logic signed [NUM_W-1:0] p1_reg;
    logic signed [NUM_W-1:0] p2_reg;
    logic [MAG_W-1:0]        quo_reg;
    logic [9:0]              rem_reg;
    logic [9:0]              den_reg;
    logic                    neg_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic signed [10:0]      da_now;
    logic signed [16:0]      dt_now;
    logic signed [10:0]      off_now;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_abs;
    logic [10:0]             da_abs;
    logic [10:0]             shifted;
    logic [11:0]             diff;
    logic signed [NUM_W-1:0] res;
    logic signed [15:0]      res_sat;
    logic [7:0]              duty;

    // Differences of the calibration points and of the new sample.
    assign da_now  = $signed({1'b0, rab_reg}) - $signed({1'b0, raa_reg});
    assign dt_now  = $signed({1'b0, ctb_reg}) - $signed({1'b0, cta_reg});
    assign off_now = $signed({1'b0, in_data.adc_sample}) - $signed({1'b0, rab_reg});

    // Numerator magnitude and divisor magnitude.
    assign num     = p1_reg + p2_reg;
    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign da_abs  = da_reg[10] ? 11'(-da_reg) : 11'(da_reg);

    // One restoring division step.
    assign shifted = {rem_reg, quo_reg[MAG_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    // Signed result for either sign and for a zero span, and its 16-bit saturation.
    always_comb
    begin
        if (da_reg == '0)
        begin
            res = NUM_W'(off_reg) + NUM_W'($signed({1'b0, ctb_reg}));
        end
        else if (neg_reg)
        begin
            res = -$signed({1'b0, quo_reg});
        end
        else
        begin
            res = $signed({1'b0, quo_reg});
        end
        if (res > NUM_W'(32767))
        begin
            res_sat = 16'sh7fff;
        end
        else if (res < -NUM_W'(32768))
        begin
            res_sat = -16'sh8000;
        end
        else
        begin
            res_sat = res[15:0];
        end
    end

    assign duty = (fan_reg == 7'd100) ? 8'd255 : ({fan_reg, 1'b0} + {2'b00, fan_reg[6:1]});

    assign sts.is_sample = (in_data.op == OP_SAMPLE);
    assign sts.zero_span = (da_reg == '0);
    assign sts.div_done  = (cnt_reg == '0);
    assign sts.out_busy  = out_valid_reg && !out_ready;

    // Controller state updated by events.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            fan_reg       <= 7'd50;
            saved_reg     <= 7'd50;
            setp_reg      <= 16'd250;
            pwr_reg       <= 7'd0;
            rta_reg       <= 16'd30;
            rtb_reg       <= 16'd50;
            raa_reg       <= 10'd108;
            rab_reg       <= 10'd200;
            last_adc_reg  <= 10'd0;
            led_reg       <= 1'b0;
            last_temp_reg <= 16'sd0;
            cta_reg       <= 16'd30;
            ctb_reg       <= 16'd50;
        end
        else
        begin
            if (cmd.fin)
            begin
                last_temp_reg <= res_sat;
            end
            if (cmd.apply)
            begin
                case (in_data.op)
                    OP_SAMPLE:
                    begin
                        last_adc_reg <= in_data.adc_sample;
                    end
                    OP_HOLDER:
                    begin
                        if (in_data.on_stand)
                        begin
                            if (mode_reg == MODE_HEAT)
                            begin
                                saved_reg <= fan_reg;
                                fan_reg   <= 7'd100;
                                mode_reg  <= MODE_PARKED;
                            end
                            else if (mode_reg == MODE_PARKED)
                            begin
                                led_reg <= !led_reg;
                            end
                        end
                        else if (mode_reg == MODE_PARKED)
                        begin
                            fan_reg  <= saved_reg;
                            mode_reg <= MODE_HEAT;
                            led_reg  <= 1'b1;
                        end
                    end
                    OP_FAN:
                    begin
                        if (in_data.clockwise)
                        begin
                            if (fan_reg < 7'd100)
                            begin
                                fan_reg <= fan_reg + 7'd1;
                            end
                        end
                        else if (fan_reg > 7'd20)
                        begin
                            fan_reg <= fan_reg - 7'd1;
                        end
                    end
                    OP_TEMP:
                    begin
                        if (in_data.clockwise)
                        begin
                            if (setp_reg < MAX_SET_TEMP)
                            begin
                                setp_reg <= setp_reg + 16'd5;
                            end
                        end
                        else if (setp_reg > MIN_SET_TEMP)
                        begin
                            setp_reg <= setp_reg - 16'd5;
                        end
                    end
                    OP_POWER:
                    begin
                        if (in_data.clockwise)
                        begin
                            if (pwr_reg < 7'd100)
                            begin
                                pwr_reg <= pwr_reg + 7'd1;
                            end
                        end
                        else if (pwr_reg > 7'd1)
                        begin
                            pwr_reg <= pwr_reg - 7'd1;
                        end
                    end
                    OP_CAL:
                    begin
                        if (in_data.cal_point)
                        begin
                            rta_reg <= in_data.clockwise ? rta_reg + 16'd1 : rta_reg - 16'd1;
                        end
                        else
                        begin
                            rtb_reg <= in_data.clockwise ? rtb_reg + 16'd1 : rtb_reg - 16'd1;
                        end
                    end
                    OP_CAPTURE:
                    begin
                        if (in_data.cal_point)
                        begin
                            raa_reg <= last_adc_reg;
                        end
                        else
                        begin
                            rab_reg <= last_adc_reg;
                        end
                        cta_reg <= rta_reg;
                        ctb_reg <= rtb_reg;
                    end
                    OP_ON:
                    begin
                        mode_reg <= MODE_HEAT;
                        led_reg  <= 1'b1;
                    end
                    OP_OFF:
                    begin
                        mode_reg <= MODE_OFF;
                        led_reg  <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Conversion pipeline: differences, products, magnitudes, division steps.
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            da_reg  <= da_now;
            dt_reg  <= dt_now;
            off_reg <= off_now;
        end
        if (cmd.mul)
        begin
            p1_reg <= NUM_W'($signed({1'b0, ctb_reg})) * NUM_W'(da_reg);
            p2_reg <= NUM_W'(dt_reg) * NUM_W'(off_reg);
        end
        if (cmd.sum)
        begin
            quo_reg <= num_abs[MAG_W-1:0];
            den_reg <= da_abs[9:0];
            rem_reg <= '0;
            neg_reg <= num[NUM_W-1] ^ da_reg[10];
            cnt_reg <= CNT_W'(MAG_W - 1);
        end
        if (cmd.div_step)
        begin
            if (!diff[11])
            begin
                rem_reg <= diff[9:0];
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[9:0];
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.power_state     <= mode_reg;
            out_reg.fan_duty        <= duty;
            out_reg.fan_drive_on    <= (mode_reg != MODE_OFF);
            out_reg.heater_drive_on <= (mode_reg == MODE_HEAT);
            out_reg.led_lit         <= led_reg;
            out_reg.fan_percent     <= fan_reg;
            out_reg.target_temp     <= setp_reg;
            out_reg.power_percent   <= pwr_reg;
            out_reg.measured_temp   <= last_temp_reg;
            out_reg.cal_temp_low    <= rta_reg;
            out_reg.cal_temp_high   <= rtb_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The running remainder stays below the divisor.
    `HASC_ASSERT_IMPLY(a_rem_bound, clk, rst_n, cmd.div_step, rem_reg < den_reg)
    // A result is never loaded over one that is still waiting.
    `HASC_ASSERT_IMPLY(a_no_overrun, clk, rst_n, cmd.load_out, !(out_valid_reg && !out_ready))
    // A stalled result beat holds its valid and its payload.
    `HASC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg && $stable(out_reg))

endmodule

// ----- sv/hot_air_station_controller_core.sv -----
// Hot-air station controller top level: one result beat per event beat.
// A non-sample event goes from acceptance straight to the result load; a sample
// passes multiply, sum, 27 divider steps, saturate and load, skipping the divider at zero span.
// Events are handled one at a time; the load waits while the output register is still full.
// The next event is accepted while a finished result still waits in the output register.
// Reset (rst_n, asynchronous, low) restores all settings and the calibration points.
module hot_air_station_controller_core
    import hasc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    hasc_in_if.sink    in_ch,
    hasc_out_if.source out_ch
);

    cmd_t cmd;
    sts_t sts;

    hasc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hasc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_ch.data),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_data  (out_ch.data)
    );

endmodule
